FILE: design/rgbacm_pkg.sv
// shared types and constants for the rgb affine colour matrix
package rgbacm_pkg;

  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned NARROW_W          = 8;
  localparam int unsigned GAIN_W            = 20;
  localparam int unsigned ROW_W             = 3 * GAIN_W;
  localparam int unsigned OFFSET_W          = 22;
  localparam int unsigned OFFSET_FRAC       = 4;
  localparam int unsigned GAIN_FRAC_DEFAULT = 12;
  localparam int unsigned PROD_W            = GAIN_W + SAMPLE_W + 1;
  localparam int unsigned ACC_W             = 40;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned NUM_STAGES        = 4;

  localparam logic [ROW_W-1:0] GAIN_RED_RESET   = ROW_W'(64'd4096);
  localparam logic [ROW_W-1:0] GAIN_GREEN_RESET = ROW_W'(64'd4096 << GAIN_W);
  localparam logic [ROW_W-1:0] GAIN_BLUE_RESET  = ROW_W'(64'd4096 << (2 * GAIN_W));

  localparam logic [SAMPLE_W-1:0] CHAN_MAX_WIDE   = '1;
  localparam logic [SAMPLE_W-1:0] CHAN_MAX_NARROW = SAMPLE_W'({NARROW_W{1'b1}});

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_RED     = 3'd0,
    CFG_GAIN_GREEN   = 3'd1,
    CFG_GAIN_BLUE    = 3'd2,
    CFG_OFFSET_RED   = 3'd3,
    CFG_OFFSET_GREEN = 3'd4,
    CFG_OFFSET_BLUE  = 3'd5,
    CFG_WIDE_MODE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
  } pixel_out_t;

  // per-stage control that travels alongside the datapath
  typedef struct packed {
    logic valid;
    logic wide;
  } stage_ctl_t;

endpackage

FILE: design/rgb_affine_color_matrix.sv
// top level of the rgb affine colour matrix
//
// usage
// - one pixel is taken at each rising edge with start_i high and busy_o low
// - busy_o is high only from reset until the first clock edge after reset
//   is released; after that a pixel may be given on every cycle
// - each result appears on pix_o for exactly one cycle with done_o high;
//   the receiver cannot stall, so nothing is held back
// - throughput is one pixel per clock once busy_o has fallen after reset
// - the four stages are: multiply, partial sums, full sum, round and clamp;
//   the gain by sample multipliers set the depth of the first stage
// - settings go in through cfg_we_i, cfg_idx_i and cfg_wdata_i, one register
//   per transfer; change them only while the pipeline is empty (not enforced)
// - reset restores identity gains, zero offsets and 16-bit mode, and
//   empties the pipeline
module rgb_affine_color_matrix #(
  parameter int unsigned GAIN_FRACTION_BITS = rgbacm_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  rgbacm_pkg::pixel_in_t               pix_i,
  output logic                                done_o,
  output rgbacm_pkg::pixel_out_t              pix_o,
  input  logic                                cfg_we_i,
  input  logic [rgbacm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rgbacm_pkg::ROW_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SmpW   = rgbacm_pkg::SAMPLE_W;
  localparam int unsigned NarW   = rgbacm_pkg::NARROW_W;
  localparam int unsigned OfsW   = rgbacm_pkg::OFFSET_W;
  localparam int unsigned Stages = rgbacm_pkg::NUM_STAGES;

  logic [rgbacm_pkg::ROW_W-1:0]  gain_q [3];
  logic signed [OfsW-1:0]        offset_q [3];
  logic                          wide_mode_q;
  logic                          busy_q;
  logic                          accept;
  rgbacm_pkg::stage_ctl_t        ctl_q [Stages];
  logic [2:0][SmpW-1:0]          smp_raw;
  logic [2:0][SmpW-1:0]          smp;
  logic [SmpW-1:0]               chan_out [3];

  assign accept = start_i && !busy_q;

  // settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0]   <= rgbacm_pkg::GAIN_RED_RESET;
      gain_q[1]   <= rgbacm_pkg::GAIN_GREEN_RESET;
      gain_q[2]   <= rgbacm_pkg::GAIN_BLUE_RESET;
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      offset_q[2] <= '0;
      wide_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (rgbacm_pkg::cfg_idx_e'(cfg_idx_i))
        rgbacm_pkg::CFG_GAIN_RED:     gain_q[0]   <= cfg_wdata_i;
        rgbacm_pkg::CFG_GAIN_GREEN:   gain_q[1]   <= cfg_wdata_i;
        rgbacm_pkg::CFG_GAIN_BLUE:    gain_q[2]   <= cfg_wdata_i;
        rgbacm_pkg::CFG_OFFSET_RED:   offset_q[0] <= cfg_wdata_i[OfsW-1:0];
        rgbacm_pkg::CFG_OFFSET_GREEN: offset_q[1] <= cfg_wdata_i[OfsW-1:0];
        rgbacm_pkg::CFG_OFFSET_BLUE:  offset_q[2] <= cfg_wdata_i[OfsW-1:0];
        rgbacm_pkg::CFG_WIDE_MODE:    wide_mode_q <= cfg_wdata_i[0];
        default: ; // unused index, write ignored
      endcase
    end
  end

  // busy only until the first edge after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // valid and mode travel with the pixel through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[0] <= '{valid: accept, wide: wide_mode_q};
      for (int s = 1; s < Stages; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // in 8-bit mode the upper sample bits are dropped
  assign smp_raw = {pix_i.blue_in, pix_i.green_in, pix_i.red_in};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      smp[k] = wide_mode_q ? smp_raw[k] : SmpW'(smp_raw[k][NarW-1:0]);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    rgbacm_channel #(
      .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_chan (
      .clk_i    (clk_i),
      .row_i    (gain_q[c]),
      .offset_i (offset_q[c]),
      .smp_i    (smp),
      .wide_i   (ctl_q[Stages-2].wide),
      .out_o    (chan_out[c])
    );
  end

  assign busy_o          = busy_q;
  assign done_o          = ctl_q[Stages-1].valid;
  assign pix_o.red_out   = chan_out[0];
  assign pix_o.green_out = chan_out[1];
  assign pix_o.blue_out  = chan_out[2];

endmodule

FILE: design/rgbacm_channel.sv
// one output channel: three products, offset, rounding and clamp over four stages
module rgbacm_channel #(
  parameter int unsigned GAIN_FRACTION_BITS = rgbacm_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                                            clk_i,
  input  logic [rgbacm_pkg::ROW_W-1:0]                    row_i,
  input  logic signed [rgbacm_pkg::OFFSET_W-1:0]          offset_i,
  input  logic [2:0][rgbacm_pkg::SAMPLE_W-1:0]            smp_i,
  input  logic                                            wide_i,
  output logic [rgbacm_pkg::SAMPLE_W-1:0]                 out_o
);

  localparam int unsigned AccW   = rgbacm_pkg::ACC_W;
  localparam int unsigned ProdW  = rgbacm_pkg::PROD_W;
  localparam int unsigned GainW  = rgbacm_pkg::GAIN_W;
  localparam int unsigned SmpW   = rgbacm_pkg::SAMPLE_W;
  localparam int unsigned NarW   = rgbacm_pkg::NARROW_W;
  localparam int unsigned MagW   = AccW - GAIN_FRACTION_BITS;
  localparam int unsigned OfsSh  = GAIN_FRACTION_BITS - rgbacm_pkg::OFFSET_FRAC;
  localparam logic signed [AccW-1:0] RoundConst = AccW'(1) <<< (GAIN_FRACTION_BITS - 1);

  logic signed [ProdW-1:0] prod_d [3];
  logic signed [ProdW-1:0] prod_q [3];
  logic signed [AccW-1:0]  ofs_term;
  logic signed [AccW-1:0]  sum01_q, sum2_q;
  logic signed [AccW-1:0]  acc_q;
  logic [MagW-1:0]         mag;
  logic [SmpW-1:0]         out_d, out_q;

  // stage a: gain times sample
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = $signed(row_i[k*GainW +: GainW]) * $signed({1'b0, smp_i[k]});
    end
  end

  assign ofs_term = AccW'(offset_i) <<< OfsSh;

  // integer part; only meaningful when the sum is not negative
  assign mag = acc_q[AccW-1:GAIN_FRACTION_BITS];

  always_comb begin
    if (acc_q[AccW-1]) begin
      out_d = '0;
    end else if (wide_i) begin
      out_d = (|mag[MagW-1:SmpW]) ? rgbacm_pkg::CHAN_MAX_WIDE : mag[SmpW-1:0];
    end else begin
      out_d = (|mag[MagW-1:NarW]) ? rgbacm_pkg::CHAN_MAX_NARROW
                                  : SmpW'(mag[NarW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
    // stage b: two partial sums, offset and half folded into the second
    sum01_q <= AccW'(prod_q[0]) + AccW'(prod_q[1]);
    sum2_q  <= AccW'(prod_q[2]) + ofs_term + RoundConst;
    // stage c: full sum
    acc_q   <= sum01_q + sum2_q;
    // stage d: drop the fraction (round to nearest, with the half) and clamp
    out_q   <= out_d;
  end

  assign out_o = out_q;

endmodule

FILE: design/rgbacm_checker.sv
// port-level checks for the rgb affine colour matrix, bound to the top level
module rgbacm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // every accepted pixel gives a result on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("accepted pixel produced no result");

  // no result without a matching accepted pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without matching transfer");

  // once ready after reset the block stays ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised after reset");

endmodule

bind rgb_affine_color_matrix rgbacm_checker u_rgbacm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
